// ===== design/csf_pkg.sv =====
package csf_pkg;

  // fixed payload widths
  localparam int unsigned KindW    = 2;
  localparam int unsigned TidW     = 8;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountW   = 16;
  localparam int unsigned WaitCntW = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // parameter defaults
  localparam int unsigned WaitDepthDef    = 16;
  localparam int unsigned ThreadIdBitsDef = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MAX_HOLDERS   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_START_HOLDERS = CfgIdxW'(1);

  typedef enum logic [KindW-1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CANCEL  = 2'd2,
    KIND_UNUSED  = 2'd3
  } csf_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_ACQUIRED = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_QUEUED   = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_RELEASED = 3'd4,
    ST_QFULL    = 3'd5,
    ST_RELERR   = 3'd6
  } csf_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SEARCH,
    S_SHIFT,
    S_MOVE,
    S_DONE
  } csf_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXEC,
    OP_POP,
    OP_SEARCH,
    OP_SHIFT,
    OP_MOVE,
    OP_RESULT
  } csf_op_e;

  typedef struct packed {
    csf_op_e op;
  } csf_cmd_t;

  typedef struct packed {
    csf_kind_e kind;
    logic      q_empty;
    logic      hit;
    logic      last;
    logic      out_busy;
  } csf_stat_t;

endpackage

// ===== design/csf_if.sv =====
// request channel
interface csf_req_if;
  logic                          valid;
  logic                          ready;
  logic [csf_pkg::KindW-1:0]     kind;
  logic [csf_pkg::TidW-1:0]      thread_id;
  logic                          wait_allowed;

  modport source (output valid, kind, thread_id, wait_allowed, input ready);
  modport sink   (input valid, kind, thread_id, wait_allowed, output ready);
endinterface

// result channel
interface csf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [csf_pkg::StatusW-1:0]   status;
  logic                          woken_valid;
  logic [csf_pkg::TidW-1:0]      woken_thread;
  logic [csf_pkg::CountW-1:0]    holder_count;
  logic [csf_pkg::WaitCntW-1:0]  waiting_count;

  modport source (output valid, status, woken_valid, woken_thread, holder_count,
                  waiting_count, input ready);
  modport sink   (input valid, status, woken_valid, woken_thread, holder_count,
                  waiting_count, output ready);
endinterface

// configuration write channel
interface csf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [csf_pkg::CfgIdxW-1:0]   index;
  logic [csf_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/csf_ram.sv =====
module csf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/csf_ctrl.sv =====
module csf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               cfg_ready_o,
  input  csf_pkg::csf_stat_t stat_i,
  output csf_pkg::csf_cmd_t  cmd_o
);

  csf_pkg::csf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      csf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = csf_pkg::S_EXEC;
        end
      end
      csf_pkg::S_EXEC: begin
        case (stat_i.kind)
          csf_pkg::KIND_RELEASE: begin
            state_d = stat_i.q_empty ? csf_pkg::S_DONE : csf_pkg::S_POP;
          end
          csf_pkg::KIND_CANCEL: begin
            state_d = stat_i.q_empty ? csf_pkg::S_DONE : csf_pkg::S_SEARCH;
          end
          default: begin
            state_d = csf_pkg::S_DONE;
          end
        endcase
      end
      csf_pkg::S_POP: begin
        state_d = csf_pkg::S_DONE;
      end
      csf_pkg::S_SEARCH: begin
        if (stat_i.hit) begin
          state_d = csf_pkg::S_SHIFT;
        end else if (stat_i.last) begin
          state_d = csf_pkg::S_DONE;
        end
      end
      csf_pkg::S_SHIFT: begin
        state_d = stat_i.last ? csf_pkg::S_DONE : csf_pkg::S_MOVE;
      end
      csf_pkg::S_MOVE: begin
        state_d = csf_pkg::S_SHIFT;
      end
      csf_pkg::S_DONE: begin
        if (!stat_i.out_busy) begin
          state_d = csf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = csf_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    cmd_o.op    = csf_pkg::OP_NONE;
    case (state_q)
      csf_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cfg_ready_o = 1'b1;
        cmd_o.op    = in_valid_i ? csf_pkg::OP_LOAD : csf_pkg::OP_NONE;
      end
      csf_pkg::S_EXEC:   cmd_o.op = csf_pkg::OP_EXEC;
      csf_pkg::S_POP:    cmd_o.op = csf_pkg::OP_POP;
      csf_pkg::S_SEARCH: cmd_o.op = csf_pkg::OP_SEARCH;
      csf_pkg::S_SHIFT:  cmd_o.op = csf_pkg::OP_SHIFT;
      csf_pkg::S_MOVE:   cmd_o.op = csf_pkg::OP_MOVE;
      csf_pkg::S_DONE: begin
        cmd_o.op = stat_i.out_busy ? csf_pkg::OP_NONE : csf_pkg::OP_RESULT;
      end
      default: cmd_o.op = csf_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== design/csf_dp.sv =====
module csf_dp #(
  parameter int unsigned WAIT_DEPTH     = csf_pkg::WaitDepthDef,
  parameter int unsigned THREAD_ID_BITS = csf_pkg::ThreadIdBitsDef,
  localparam int unsigned PtrW = $clog2(WAIT_DEPTH),
  localparam int unsigned LenW = $clog2(WAIT_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csf_pkg::csf_cmd_t             cmd_i,
  output csf_pkg::csf_stat_t            stat_o,
  // request payload
  input  logic [csf_pkg::KindW-1:0]     kind_i,
  input  logic [csf_pkg::TidW-1:0]      thread_id_i,
  input  logic                          wait_allowed_i,
  // configuration write
  input  logic                          cfg_we_i,
  input  logic [csf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [csf_pkg::CfgDataW-1:0]  cfg_data_i,
  // result
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [csf_pkg::StatusW-1:0]   status_o,
  output logic                          woken_valid_o,
  output logic [csf_pkg::TidW-1:0]      woken_thread_o,
  output logic [csf_pkg::CountW-1:0]    holder_count_o,
  output logic [csf_pkg::WaitCntW-1:0]  waiting_count_o,
  // wait queue memory
  output logic                          ram_we_o,
  output logic [PtrW-1:0]               ram_waddr_o,
  output logic [THREAD_ID_BITS-1:0]     ram_wdata_o,
  output logic [PtrW-1:0]               ram_raddr_o,
  input  logic [THREAD_ID_BITS-1:0]     ram_rdata_i
);

  localparam int unsigned SumW = PtrW + 1;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(WAIT_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // control state
  logic [csf_pkg::CountW-1:0]   holders_q, holders_d;
  logic [csf_pkg::CfgDataW-1:0] max_q, max_d;
  logic [csf_pkg::CfgDataW-1:0] start_q, start_d;
  logic [LenW-1:0]              len_q, len_d;
  logic [PtrW-1:0]              head_q, head_d;
  logic                         out_valid_q;

  // per request working registers
  csf_pkg::csf_kind_e           kind_q, kind_d;
  logic [THREAD_ID_BITS-1:0]    tid_q, tid_d;
  logic                         wait_q, wait_d;
  logic [PtrW-1:0]              ptr_q, ptr_d;
  logic [PtrW-1:0]              idx_q, idx_d;
  csf_pkg::csf_status_e         st_q, st_d;
  logic                         wv_q, wv_d;
  logic [THREAD_ID_BITS-1:0]    wt_q, wt_d;

  // result register
  logic [csf_pkg::StatusW-1:0]  out_status_q;
  logic                         out_wv_q;
  logic [csf_pkg::TidW-1:0]     out_wt_q;
  logic [csf_pkg::CountW-1:0]   out_holders_q;
  logic [csf_pkg::WaitCntW-1:0] out_len_q;

  logic [csf_pkg::CountW-1:0]   lim;
  logic                         grant_ok;
  logic                         q_full;
  logic                         q_empty;
  logic                         hit;
  logic                         last;
  logic [SumW-1:0]              tail_sum;
  logic [PtrW-1:0]              tail;
  logic [15:0]                  tid_wide;
  logic [15:0]                  wt_wide;
  logic [15:0]                  len_wide;
  logic [csf_pkg::CfgDataW-1:0] cfg_max;
  logic [csf_pkg::CfgDataW-1:0] cfg_start;
  logic [csf_pkg::CfgDataW-1:0] cfg_lim;
  logic                         cfg_load;
  logic                         ram_we;
  logic [PtrW-1:0]              ram_waddr;
  logic [THREAD_ID_BITS-1:0]    ram_wdata;

  // flags
  assign lim      = (max_q == '0) ? csf_pkg::CountW'(1) : max_q;
  assign grant_ok = holders_q < lim;
  assign q_full   = len_q == LenW'(WAIT_DEPTH);
  assign q_empty  = len_q == '0;
  assign hit      = ram_rdata_i == tid_q;
  assign last     = (LenW'(idx_q) + LenW'(1)) == len_q;

  // free slot behind the tail of the circular queue
  assign tail_sum = SumW'(head_q) + SumW'(len_q);
  assign tail     = (tail_sum >= SumW'(WAIT_DEPTH)) ? PtrW'(tail_sum - SumW'(WAIT_DEPTH))
                                                    : PtrW'(tail_sum);

  // thread id masked to the stored width
  assign tid_wide = 16'(thread_id_i);

  // reload values for a configuration write
  assign cfg_max   = (cfg_idx_i == csf_pkg::REG_MAX_HOLDERS) ? cfg_data_i : max_q;
  assign cfg_start = (cfg_idx_i == csf_pkg::REG_START_HOLDERS) ? cfg_data_i : start_q;
  assign cfg_lim   = (cfg_max == '0) ? csf_pkg::CfgDataW'(1) : cfg_max;

  // only writes to a known register reload the semaphore
  assign cfg_load = cfg_we_i &
                    (cfg_idx_i inside {csf_pkg::REG_MAX_HOLDERS, csf_pkg::REG_START_HOLDERS});

  // next state of the datapath
  always_comb begin
    holders_d = holders_q;
    max_d     = max_q;
    start_d   = start_q;
    len_d     = len_q;
    head_d    = head_q;
    kind_d    = kind_q;
    tid_d     = tid_q;
    wait_d    = wait_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    st_d      = st_q;
    wv_d      = wv_q;
    wt_d      = wt_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata_i;

    case (cmd_i.op)
      csf_pkg::OP_LOAD: begin
        kind_d = csf_pkg::csf_kind_e'(kind_i);
        tid_d  = tid_wide[THREAD_ID_BITS-1:0];
        wait_d = wait_allowed_i;
        wv_d   = 1'b0;
        wt_d   = '0;
      end
      csf_pkg::OP_EXEC: begin
        case (kind_q)
          csf_pkg::KIND_ACQUIRE: begin
            if (grant_ok) begin
              holders_d = holders_q + csf_pkg::CountW'(1);
              st_d      = csf_pkg::ST_ACQUIRED;
            end else if (!wait_q) begin
              st_d = csf_pkg::ST_REFUSED;
            end else if (q_full) begin
              st_d = csf_pkg::ST_QFULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = tail;
              ram_wdata = tid_q;
              len_d     = len_q + LenW'(1);
              st_d      = csf_pkg::ST_QUEUED;
            end
          end
          csf_pkg::KIND_RELEASE: begin
            // a waiter is popped in the next step
            if (q_empty) begin
              if (holders_q == '0) begin
                st_d = csf_pkg::ST_RELERR;
              end else begin
                holders_d = holders_q - csf_pkg::CountW'(1);
                st_d      = csf_pkg::ST_RELEASED;
              end
            end
          end
          csf_pkg::KIND_CANCEL: begin
            // no match found means the slot was already handed over
            st_d  = csf_pkg::ST_ACQUIRED;
            ptr_d = head_q;
            idx_d = '0;
          end
          default: begin
            st_d = csf_pkg::ST_REFUSED;
          end
        endcase
      end
      csf_pkg::OP_POP: begin
        wv_d   = 1'b1;
        wt_d   = ram_rdata_i;
        head_d = ptr_inc(head_q);
        len_d  = len_q - LenW'(1);
        st_d   = csf_pkg::ST_RELEASED;
      end
      csf_pkg::OP_SEARCH: begin
        if (hit) begin
          st_d = csf_pkg::ST_TIMEOUT;
        end else if (!last) begin
          ptr_d = ptr_inc(ptr_q);
          idx_d = idx_q + PtrW'(1);
        end
      end
      csf_pkg::OP_SHIFT: begin
        if (last) begin
          len_d = len_q - LenW'(1);
        end
      end
      csf_pkg::OP_MOVE: begin
        // entry behind moves one place toward the head
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata_i;
        ptr_d     = ptr_inc(ptr_q);
        idx_d     = idx_q + PtrW'(1);
      end
      default: begin
      end
    endcase

    // configuration reloads the count and empties the queue
    if (cfg_load) begin
      max_d     = cfg_max;
      start_d   = cfg_start;
      holders_d = (cfg_start > cfg_lim) ? cfg_lim : cfg_start;
      len_d     = '0;
      head_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holders_q <= '0;
      max_q     <= csf_pkg::CfgDataW'(1);
      start_q   <= '0;
      len_q     <= '0;
      head_q    <= '0;
    end else begin
      holders_q <= holders_d;
      max_q     <= max_d;
      start_q   <= start_d;
      len_q     <= len_d;
      head_q    <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    tid_q  <= tid_d;
    wait_q <= wait_d;
    ptr_q  <= ptr_d;
    idx_q  <= idx_d;
    st_q   <= st_d;
    wv_q   <= wv_d;
    wt_q   <= wt_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == csf_pkg::OP_RESULT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign wt_wide  = 16'(wt_q);
  assign len_wide = 16'(len_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == csf_pkg::OP_RESULT) begin
      out_status_q  <= st_q;
      out_wv_q      <= wv_q;
      out_wt_q      <= wt_wide[csf_pkg::TidW-1:0];
      out_holders_q <= holders_q;
      out_len_q     <= len_wide[csf_pkg::WaitCntW-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign woken_valid_o   = out_wv_q;
  assign woken_thread_o  = out_wt_q;
  assign holder_count_o  = out_holders_q;
  assign waiting_count_o = out_len_q;

  // memory: head on exec, otherwise the entry after the scan pointer
  assign ram_we_o    = ram_we;
  assign ram_waddr_o = ram_waddr;
  assign ram_wdata_o = ram_wdata;
  assign ram_raddr_o = (cmd_i.op == csf_pkg::OP_EXEC) ? head_q : ptr_inc(ptr_q);

  // status toward the controller
  assign stat_o.kind     = kind_q;
  assign stat_o.q_empty  = q_empty;
  assign stat_o.hit      = hit;
  assign stat_o.last     = last;
  assign stat_o.out_busy = out_valid_q & ~out_ready_i;

endmodule

// ===== design/counting_semaphore_fifo_waiters_unit.sv =====
// Counting semaphore with a FIFO queue of waiting thread ids.
// req_i takes one request (acquire, release or cancel of a pending wait);
// every request gives exactly one result on rsp_o with the status, the
// thread woken by a release, and the holder and waiting counts after it.
// cfg_i writes max_holders (index 0) or start_holders (index 1); either
// write reloads the holder count, clamped to the limit, and empties the
// queue. cfg_i is ready only while no request is in progress.
// Steps from the accept to a valid result: acquire, release with no
//   waiter and the unused kind execute and then load the result; a
//   release that wakes a waiter adds one read of the queue head; cancel
//   searches the queue from the head until a match or the last entry,
//   and after a match every entry behind it moves up one place toward
//   the head, each in a shift and a move step through the queue memory.
// A new request is taken in the cycle after the result is loaded.
// The result register holds while rsp_o is stalled and the next request
// is still accepted; its completion waits until the result is taken.
// Reset empties the queue, clears the holder count and sets the limit
// to 1; the queue memory itself needs no clearing.
module counting_semaphore_fifo_waiters_unit #(
  parameter int unsigned WAIT_DEPTH     = csf_pkg::WaitDepthDef,
  parameter int unsigned THREAD_ID_BITS = csf_pkg::ThreadIdBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  csf_req_if.sink   req_i,
  csf_rsp_if.source rsp_o,
  csf_cfg_if.sink   cfg_i
);

  localparam int unsigned PtrW = $clog2(WAIT_DEPTH);

  csf_pkg::csf_cmd_t         cmd;
  csf_pkg::csf_stat_t        stat;
  logic                      in_ready;
  logic                      cfg_ready;
  logic                      ram_we;
  logic [PtrW-1:0]           ram_waddr;
  logic [THREAD_ID_BITS-1:0] ram_wdata;
  logic [PtrW-1:0]           ram_raddr;
  logic [THREAD_ID_BITS-1:0] ram_rdata;

  assign req_i.ready = in_ready;
  assign cfg_i.ready = cfg_ready;

  // sequencer
  csf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .cfg_ready_o (cfg_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // counts, queue pointers and result register
  csf_dp #(
    .WAIT_DEPTH     (WAIT_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (req_i.kind),
    .thread_id_i     (req_i.thread_id),
    .wait_allowed_i  (req_i.wait_allowed),
    .cfg_we_i        (cfg_i.valid & cfg_ready),
    .cfg_idx_i       (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .status_o        (rsp_o.status),
    .woken_valid_o   (rsp_o.woken_valid),
    .woken_thread_o  (rsp_o.woken_thread),
    .holder_count_o  (rsp_o.holder_count),
    .waiting_count_o (rsp_o.waiting_count),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  // wait queue storage
  csf_ram #(
    .Width (THREAD_ID_BITS),
    .Depth (WAIT_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
